### hdl/tppr_pkg.sv
// ----------------------------------------------------------------------------
// tppr_pkg: shared types and constants for the timer period calculator
// beat layouts, status codes and the step items that flow through both
// divider chains
// ----------------------------------------------------------------------------
package tppr_pkg;

  // number of timer slots; valid ids run from 1 to TIMER_SLOTS-1
  localparam logic [4:0] TIMER_SLOTS = 5'd8;

  // divisor that turns clock * period into ticks
  localparam logic [20:0] US_PER_SEC = 21'd1000000;

  // smallest product whose tick count lies above 2^32: (2^32 + 1) * 1e6
  localparam logic [63:0] TICK_OVER_PROD = 64'd4294967297000000;

  // prescaler and reload both span 1..65536
  localparam logic [16:0] WORD_SPAN = 17'h10000;

  // one cell per dividend bit in each chain
  localparam int TICK_STEPS = 64;
  localparam int RLD_STEPS  = 33;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_ARG = 2'd1,
    ST_TICKS   = 2'd2,
    ST_RELOAD  = 2'd3
  } status_e;

  typedef struct packed {
    logic [3:0]  timer_id;
    logic [31:0] clock_hz;
    logic [31:0] period_us;
  } in_beat_t;

  typedef struct packed {
    logic [15:0] prescale_word;
    logic [15:0] reload_word;
    status_e     status;
  } out_beat_t;

  // item moving through the divide-by-1e6 chain
  typedef struct packed {
    logic [63:0] num;
    logic [19:0] rem;
    logic [32:0] quo;
    logic        bad;
    logic        over;
  } tick_item_t;

  // item moving through the divide-by-prescaler chain
  typedef struct packed {
    logic [32:0] num;
    logic [16:0] rem;
    logic [16:0] psc;
    logic [32:0] quo;
    logic        bad;
    logic        over;
  } rld_item_t;

endpackage

### hdl/tppr_tick_cell.sv
// ----------------------------------------------------------------------------
// tppr_tick_cell: one restoring-division step by 1e6
// shifts in one dividend bit, compares against the constant divisor and
// hands the updated item to the next cell
// ----------------------------------------------------------------------------
module tppr_tick_cell
  import tppr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       valid_i,
  input  tick_item_t item_i,
  output logic       valid_o,
  output tick_item_t item_o
);

  logic        valid_q;
  tick_item_t  item_q;
  tick_item_t  item_d;
  logic [20:0] partial;
  logic [20:0] diff;
  logic        ge;

  always_comb begin
    partial = {item_i.rem, item_i.num[63]};
    diff    = partial - US_PER_SEC;
    ge      = partial >= US_PER_SEC;
    item_d      = item_i;
    item_d.num  = {item_i.num[62:0], 1'b0};
    item_d.rem  = ge ? diff[19:0] : partial[19:0];
    item_d.quo  = {item_i.quo[31:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

### hdl/tppr_reload_cell.sv
// ----------------------------------------------------------------------------
// tppr_reload_cell: one restoring-division step by the prescaler
// the divisor travels with the item so every cell works on its own beat
// ----------------------------------------------------------------------------
module tppr_reload_cell
  import tppr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      valid_i,
  input  rld_item_t item_i,
  output logic      valid_o,
  output rld_item_t item_o
);

  logic        valid_q;
  rld_item_t   item_q;
  rld_item_t   item_d;
  logic [17:0] partial;
  logic [17:0] divisor;
  logic [17:0] diff;
  logic        ge;

  always_comb begin
    partial = {item_i.rem, item_i.num[32]};
    divisor = {1'b0, item_i.psc};
    diff    = partial - divisor;
    ge      = partial >= divisor;
    item_d      = item_i;
    item_d.num  = {item_i.num[31:0], 1'b0};
    item_d.rem  = ge ? diff[16:0] : partial[16:0];
    item_d.quo  = {item_i.quo[31:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

### hdl/timer_period_to_prescale_reload.sv
// ----------------------------------------------------------------------------
// timer_period_to_prescale_reload: timer prescaler / auto-reload calculator
// turns a timer id, an input clock in hz and a period in us into the 16-bit
// prescaler and auto-reload words (each minus one) plus a status code
// ----------------------------------------------------------------------------
// One beat in, one beat out. A new request can be taken every cycle while the
// skid buffer is empty; each request passes the 32x32 multiplier register, 64
// cells of the divide-by-1e6 chain (one dividend bit per cell), the s1, s2 and
// reload head registers that form the tick count, prescaler and rounded reload
// dividend, 33 cells of the divide-by-prescaler chain, and the output register.
// The pipeline halts only while the one-entry skid buffer behind the output
// register is full, which happens when the output is stalled; in_stall_o is
// that skid flag, so it is registered. Status is 0 for success, 1 for a bad
// timer id or a zero clock or period, 2 for a tick count above 2^32 and 3 for
// a reload above 65536; on any error both words read zero.
module timer_period_to_prescale_reload
  import tppr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_beat_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_beat_o
);

  // whole pipeline moves together unless the skid entry is occupied
  logic adv;

  // multiplier stage
  logic        mul_v_q;
  logic [63:0] prod_q;
  logic        mul_bad_q;
  logic        bad_d;

  // divide-by-1e6 chain
  logic       tick_v [TICK_STEPS+1];
  tick_item_t tick_it [TICK_STEPS+1];
  tick_item_t tick_feed;

  // tick count, prescaler and reload dividend stages
  logic        s1_v_q, s2_v_q, s3_v_q;
  logic [32:0] s1_ticks_q, s2_ticks_q;
  logic        s1_bad_q, s1_over_q, s2_bad_q, s2_over_q;
  logic [32:0] s1_ticks_d;
  logic [16:0] psc_d, s2_psc_q;
  logic [33:0] round_sum;
  logic [16:0] psc_raw;
  logic [33:0] rld_sum;
  rld_item_t   rld_head_q;

  // divide-by-prescaler chain
  logic      rld_v [RLD_STEPS+1];
  rld_item_t rld_it [RLD_STEPS+1];

  // result formatting and output side
  rld_item_t   fin;
  logic        fin_v;
  out_beat_t   fin_beat;
  logic [32:0] arr;
  logic [16:0] psc_m1;
  logic [32:0] arr_m1;

  logic      out_v_q, out_v_d;
  out_beat_t out_q, out_d;
  logic      skid_v_q, skid_v_d;
  out_beat_t skid_q, skid_d;
  logic      out_free;

  assign adv        = !skid_v_q;
  assign in_stall_o = skid_v_q;

  // argument check: id outside 1..TIMER_SLOTS-1, zero clock or zero period
  assign bad_d = (in_beat_i.timer_id == 4'd0) ||
                 ({1'b0, in_beat_i.timer_id} >= TIMER_SLOTS) ||
                 (in_beat_i.clock_hz == 32'd0) ||
                 (in_beat_i.period_us == 32'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_v_q <= 1'b0;
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
    end else if (adv) begin
      mul_v_q <= in_valid_i;
      s1_v_q  <= tick_v[TICK_STEPS];
      s2_v_q  <= s1_v_q;
      s3_v_q  <= s2_v_q;
    end
  end

  // 32x32 product, always fits 64 bits
  always_ff @(posedge clk_i) begin
    if (adv) begin
      prod_q    <= {32'd0, in_beat_i.clock_hz} * {32'd0, in_beat_i.period_us};
      mul_bad_q <= bad_d;
    end
  end

  // feed of the tick chain; the overflow test is a plain product compare
  always_comb begin
    tick_feed.num  = prod_q;
    tick_feed.rem  = '0;
    tick_feed.quo  = '0;
    tick_feed.bad  = mul_bad_q;
    tick_feed.over = prod_q >= TICK_OVER_PROD;
  end

  assign tick_v[0]  = mul_v_q;
  assign tick_it[0] = tick_feed;

  for (genvar i = 0; i < TICK_STEPS; i++) begin : g_tick
    tppr_tick_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (tick_v[i]),
      .item_i  (tick_it[i]),
      .valid_o (tick_v[i+1]),
      .item_o  (tick_it[i+1])
    );
  end

  // low 33 quotient bits are exact whenever the count is not too large
  assign s1_ticks_d = (tick_it[TICK_STEPS].quo == 33'd0) ? 33'd1
                                                          : tick_it[TICK_STEPS].quo;

  // prescaler = ceil(ticks / 65536), clamped to 1..65536
  always_comb begin
    round_sum = {1'b0, s1_ticks_q} + 34'hFFFF;
    psc_raw   = round_sum[32:16];
    if (psc_raw == 17'd0) begin
      psc_d = 17'd1;
    end else if (psc_raw > WORD_SPAN) begin
      psc_d = WORD_SPAN;
    end else begin
      psc_d = psc_raw;
    end
  end

  // reload dividend rounded up: ticks + psc - 1
  assign rld_sum = {1'b0, s2_ticks_q} + {17'd0, s2_psc_q} - 34'd1;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_ticks_q <= s1_ticks_d;
      s1_bad_q   <= tick_it[TICK_STEPS].bad;
      s1_over_q  <= tick_it[TICK_STEPS].over;
      s2_ticks_q <= s1_ticks_q;
      s2_psc_q   <= psc_d;
      s2_bad_q   <= s1_bad_q;
      s2_over_q  <= s1_over_q;
      rld_head_q.num  <= rld_sum[32:0];
      rld_head_q.rem  <= '0;
      rld_head_q.psc  <= s2_psc_q;
      rld_head_q.quo  <= '0;
      rld_head_q.bad  <= s2_bad_q;
      rld_head_q.over <= s2_over_q;
    end
  end

  assign rld_v[0]  = s3_v_q;
  assign rld_it[0] = rld_head_q;

  for (genvar j = 0; j < RLD_STEPS; j++) begin : g_rld
    tppr_reload_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (rld_v[j]),
      .item_i  (rld_it[j]),
      .valid_o (rld_v[j+1]),
      .item_o  (rld_it[j+1])
    );
  end

  assign fin   = rld_it[RLD_STEPS];
  assign fin_v = rld_v[RLD_STEPS];

  // result formatting; errors force both words to zero
  always_comb begin
    arr    = (fin.quo == 33'd0) ? 33'd1 : fin.quo;
    psc_m1 = fin.psc - 17'd1;
    arr_m1 = arr - 33'd1;
    fin_beat.prescale_word = '0;
    fin_beat.reload_word   = '0;
    if (fin.bad) begin
      fin_beat.status = ST_BAD_ARG;
    end else if (fin.over) begin
      fin_beat.status = ST_TICKS;
    end else if (arr > {16'd0, WORD_SPAN}) begin
      fin_beat.status = ST_RELOAD;
    end else begin
      fin_beat.status        = ST_OK;
      fin_beat.prescale_word = psc_m1[15:0];
      fin_beat.reload_word   = arr_m1[15:0];
    end
  end

  // output register with a one-entry skid behind it
  always_comb begin
    out_free = !out_v_q || !out_stall_i;
    out_v_d  = out_v_q;
    out_d    = out_q;
    skid_v_d = skid_v_q;
    skid_d   = skid_q;
    if (out_free) begin
      if (skid_v_q) begin
        out_v_d  = 1'b1;
        out_d    = skid_q;
        skid_v_d = 1'b0;
      end else begin
        out_v_d = fin_v;
        out_d   = fin_beat;
      end
    end else if (fin_v && adv) begin
      // output is held, park the beat leaving the chain
      skid_v_d = 1'b1;
      skid_d   = fin_beat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_v_q;
  assign out_beat_o  = out_q;

endmodule

### verif/tppr_result_check.sv
// ----------------------------------------------------------------------------
// tppr_result_check: result checker for the timer period calculator
// watches both channels, works out the prescaler / reload words for every
// accepted request and compares them in order with the output beats
// ----------------------------------------------------------------------------
module tppr_result_check
  import tppr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  in_beat_t  in_beat_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  out_beat_t out_beat_i,
  output int        err_count_o,
  output int        pending_o
);

  localparam logic [63:0] MICROS_PER_SEC = 64'd1000000;
  localparam logic [63:0] MAX_TICKS      = 64'h1_0000_0000;
  localparam logic [63:0] SPAN           = 64'h1_0000;

  out_beat_t words_due_q[$];
  int        n_fail = 0;

  // prescaler / reload words for one request
  function automatic out_beat_t calc_timer_words(input in_beat_t b);
    logic [63:0] ticks;
    logic [63:0] psc;
    logic [63:0] arr;
    out_beat_t   r;
    r.prescale_word = '0;
    r.reload_word   = '0;
    r.status        = ST_OK;
    if (b.timer_id == 4'd0 || {1'b0, b.timer_id} >= TIMER_SLOTS ||
        b.clock_hz == 32'd0 || b.period_us == 32'd0) begin
      r.status = ST_BAD_ARG;
      return r;
    end
    ticks = (64'(b.clock_hz) * 64'(b.period_us)) / MICROS_PER_SEC;
    if (ticks == 64'd0) ticks = 64'd1;
    if (ticks > MAX_TICKS) begin
      r.status = ST_TICKS;
      return r;
    end
    psc = (ticks + SPAN - 64'd1) / SPAN;
    if (psc == 64'd0) psc = 64'd1;
    if (psc > SPAN) psc = SPAN;
    arr = (ticks + psc - 64'd1) / psc;
    if (arr == 64'd0) arr = 64'd1;
    if (arr > SPAN) begin
      r.status = ST_RELOAD;
      return r;
    end
    r.prescale_word = 16'(psc - 64'd1);
    r.reload_word   = 16'(arr - 64'd1);
    return r;
  endfunction

  always @(posedge clk_i) begin : watch
    out_beat_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) words_due_q.push_back(calc_timer_words(in_beat_i));
      if (out_valid_i && !out_stall_i) begin
        if (words_due_q.size() == 0) begin
          n_fail = n_fail + 1;
          if (n_fail <= 10)
            $display("unexpected result beat: psc %h rld %h st %0d", out_beat_i.prescale_word,
                     out_beat_i.reload_word, out_beat_i.status);
        end else begin
          want = words_due_q.pop_front();
          if (want.prescale_word !== out_beat_i.prescale_word ||
              want.reload_word !== out_beat_i.reload_word ||
              want.status !== out_beat_i.status) begin
            n_fail = n_fail + 1;
            if (n_fail <= 10)
              $display("result mismatch: exp psc %h rld %h st %0d, got psc %h rld %h st %0d",
                       want.prescale_word, want.reload_word, want.status,
                       out_beat_i.prescale_word, out_beat_i.reload_word, out_beat_i.status);
          end
        end
      end
    end
    err_count_o <= n_fail;
    pending_o   <= words_due_q.size();
  end

endmodule

### verif/timer_period_to_prescale_reload_test.sv
// ----------------------------------------------------------------------------
// timer_period_to_prescale_reload_test: stimulus for the timer calculator
// drives directed corner requests and then random ones, with random idling
// on both channels, a long output hold-off and a full drain pause; the
// checker beside the block does all the prediction and comparison
// ----------------------------------------------------------------------------
module timer_period_to_prescale_reload_test;
  import tppr_pkg::*;

  // idle tail after the final drain, before the verdict
  localparam int DRAIN_CYCLES = 140;
  localparam int LONG_HOLD    = 400;
  localparam int RANDOM_BEATS = 1800;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_beat_t  in_beat_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_beat_t out_beat_o;

  int        err_count;
  int        pending;

  // shared between the sender and the receiver process
  bit        hold_req = 1'b0;  // ask the receiver for one long hold-off
  bit        quiet    = 1'b0;  // last part of the run: no idling anywhere

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  timer_period_to_prescale_reload dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_beat_i   (in_beat_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o)
  );

  tppr_result_check u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_beat_i   (in_beat_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_i  (out_beat_o),
    .err_count_o (err_count),
    .pending_o   (pending)
  );

  // hold a request beat until the block takes it; valid stays high on return
  task automatic send_beat(input logic [3:0] id, input logic [31:0] clk_hz,
                           input logic [31:0] per_us);
    in_beat_t b;
    b.timer_id  = id;
    b.clock_hz  = clk_hz;
    b.period_us = per_us;
    in_valid_i <= 1'b1;
    in_beat_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // drop valid and wait until the checker has nothing outstanding
  task automatic drain_all();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // log-spread 32-bit value, sometimes zero, so tick counts cover all scales
  function automatic logic [31:0] spread_word();
    if ($urandom_range(0, 24) == 0) return 32'd0;
    return $urandom >> $urandom_range(0, 31);
  endfunction

  // sender: directed corners, then random requests
  initial begin : sender
    logic [3:0] id;
    in_valid_i <= 1'b0;
    in_beat_i  <= '0;
    rst_ni     <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // bad arguments: id zero, id at and above the slot count, zero clock or period
    send_beat(4'd0, 32'd1000000, 32'd1000);
    send_beat(4'(TIMER_SLOTS), 32'd1000000, 32'd1000);
    send_beat(4'd15, 32'd1000000, 32'd1000);
    send_beat(4'd1, 32'd0, 32'd1000);
    send_beat(4'd7, 32'd48000000, 32'd0);
    send_beat(4'd3, 32'd0, 32'd0);
    // zero tick count gets raised to one
    send_beat(4'd1, 32'd1, 32'd1);
    send_beat(4'd2, 32'd999999, 32'd1);
    // prescaler steps from 1 to 2 across 65536 ticks
    send_beat(4'd7, 32'd65536, 32'd1000000);
    send_beat(4'd7, 32'd65537, 32'd1000000);
    // exactly 2^32 ticks is still accepted, one more product step is not
    send_beat(4'd4, 32'h8000_0000, 32'd2000000);
    send_beat(4'd4, 32'h8000_0000, 32'd2000001);
    send_beat(4'd5, 32'd1000000, 32'd4294967);
    // field extremes
    send_beat(4'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_beat(4'd1, 32'hFFFF_FFFF, 32'd1);
    send_beat(4'd1, 32'd1, 32'hFFFF_FFFF);
    // everyday timer setups
    send_beat(4'd2, 32'd48000000, 32'd1000);
    send_beat(4'd3, 32'd72000000, 32'd1000000);
    send_beat(4'd5, 32'd8000000, 32'd20000);
    drain_all();

    // random part: the first few hundred go back to back against a long hold-off
    hold_req = 1'b1;
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n == RANDOM_BEATS - 300) quiet = 1'b1;
      // one full pause mid-run
      if (n == RANDOM_BEATS / 2) drain_all();
      else if (!quiet && n > 350 && (n % 200) < 140 && $urandom_range(0, 4) == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end
      // mostly well-formed ids, some out of range
      if ($urandom_range(0, 6) == 0) id = 4'($urandom_range(0, 15));
      else id = 4'($urandom_range(1, TIMER_SLOTS - 1));
      send_beat(id, spread_word(), spread_word());
    end

    drain_all();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0 && pending == 0) begin
      $display("PASS timer_period_to_prescale_reload");
    end else begin
      $display("FAIL timer_period_to_prescale_reload");
    end
    $finish;
  end

  // receiver: random stall bursts and run stretches, one long hold on request
  initial begin : receiver
    out_stall_i <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_req) begin
        // long hold-off fills the pipeline and the skid, so the input stalls
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        repeat (quiet ? 1 : $urandom_range(1, 40)) @(posedge clk_i);
      end
    end
  end

  // hang guard, far beyond the slowest legal run
  initial begin : watchdog
    #2000000;
    $display("FAIL timer_period_to_prescale_reload");
    $finish;
  end

endmodule
